[sv/pseg_pkg.sv]
// Shared types and constants for the point-to-segment projection block.
// No dependencies.
package pseg_pkg;
   // Comparison outcome of dot(w,d) against the squared segment length.
   typedef enum logic [1:0] {
      SEL_START = 2'd0,
      SEL_END   = 2'd1,
      SEL_RATIO = 2'd2
   } sel_type;
endpackage

[sv/pseg_div_stage.sv]
// One restoring-division step: shift the remainder, subtract if it fits.
// Depends on pseg_pkg.
module pseg_div_stage import pseg_pkg::*; #(
   parameter int REM_WIDTH = 68,
   parameter int Q_WIDTH   = 24
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [REM_WIDTH-1:0] rem_in,
   input  logic [REM_WIDTH-1:0] den_in,
   input  logic [Q_WIDTH-1:0]   quo_in,
   output logic [REM_WIDTH-1:0] rem_out,
   output logic [REM_WIDTH-1:0] den_out,
   output logic [Q_WIDTH-1:0]   quo_out
);
   logic [REM_WIDTH:0]   shifted;
   logic                 fits;
   logic [REM_WIDTH-1:0] rem_ff, rem_in_nx;
   logic [REM_WIDTH-1:0] den_ff;
   logic [Q_WIDTH-1:0]   quo_ff;

   // remainder stays below the divisor, so the shifted value fits one more bit
   always_comb begin
      shifted   = {rem_in, 1'b0};
      fits      = shifted >= {1'b0, den_in};
      rem_in_nx = fits ? REM_WIDTH'(shifted - {1'b0, den_in}) : shifted[REM_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in_nx;
         den_ff <= den_in;
         quo_ff <= {quo_in[Q_WIDTH-2:0], fits};
      end
   end

   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;
endmodule

[sv/point_to_segment_projection.sv]
// Top level of the point-to-segment projection pipeline.
// Depends on pseg_pkg and pseg_div_stage.
//
// channel | dir | handshake          | word
// req     | in  | req_tvalid/tready  | px, py, ax, ay, bx, by
// rsp     | out | rsp_tvalid/tready  | proj_x, proj_y
//
// One word per cycle while the output register is free or being read. The
// stages are one divider step per quotient bit plus difference, product,
// dot, compare, place and output stages. All stages advance together when
// the output register is free or being read. Reset clears the valid bits only.
module point_to_segment_projection import pseg_pkg::*; #(
   parameter int COORD_WIDTH     = 32,
   parameter int FRAC_BITS       = 16,
   parameter int RATIO_FRAC_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
   input  logic [6*COORD_WIDTH-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // proj_x, proj_y
   output logic [2*COORD_WIDTH-1:0] rsp_tdata
);
   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;          // difference width
   localparam int PW  = 2 * DW;          // product width
   localparam int SW  = PW + 1;          // dot / length width
   localparam int QW  = RATIO_FRAC_BITS;
   localparam int NST = QW + 6;
   localparam int FRAC_UNUSED = FRAC_BITS; // ratios make output independent of it

   logic [NST-1:0] vld_ff;
   logic           advance;

   // pipeline moves when the last stage is empty or drained
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid && (FRAC_UNUSED >= 0)};
      end
   end

   // stage 1: differences
   logic signed [CW-1:0] px, py, ax, ay, bx, by;
   assign px = req_tdata[0*CW +: CW];
   assign py = req_tdata[1*CW +: CW];
   assign ax = req_tdata[2*CW +: CW];
   assign ay = req_tdata[3*CW +: CW];
   assign bx = req_tdata[4*CW +: CW];
   assign by = req_tdata[5*CW +: CW];

   logic signed [DW-1:0] dx1_ff, dy1_ff, wx1_ff, wy1_ff;
   logic signed [CW-1:0] ax1_ff, ay1_ff, bx1_ff, by1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dx1_ff <= DW'(bx) - DW'(ax);
         dy1_ff <= DW'(by) - DW'(ay);
         wx1_ff <= DW'(px) - DW'(ax);
         wy1_ff <= DW'(py) - DW'(ay);
         ax1_ff <= ax; ay1_ff <= ay; bx1_ff <= bx; by1_ff <= by;
      end
   end

   // stage 2: products
   logic signed [PW-1:0] pwx2_ff, pwy2_ff, pdx2_ff, pdy2_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff;
   logic signed [CW-1:0] ax2_ff, ay2_ff, bx2_ff, by2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         pwx2_ff <= PW'(wx1_ff) * PW'(dx1_ff);
         pwy2_ff <= PW'(wy1_ff) * PW'(dy1_ff);
         pdx2_ff <= PW'(dx1_ff) * PW'(dx1_ff);
         pdy2_ff <= PW'(dy1_ff) * PW'(dy1_ff);
         dx2_ff <= dx1_ff; dy2_ff <= dy1_ff;
         ax2_ff <= ax1_ff; ay2_ff <= ay1_ff; bx2_ff <= bx1_ff; by2_ff <= by1_ff;
      end
   end

   // stage 3: dot product and squared length
   logic signed [SW-1:0] dot3_ff, len3_ff;
   logic signed [DW-1:0] dx3_ff, dy3_ff;
   logic signed [CW-1:0] ax3_ff, ay3_ff, bx3_ff, by3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dot3_ff <= SW'(pwx2_ff) + SW'(pwy2_ff);
         len3_ff <= SW'(pdx2_ff) + SW'(pdy2_ff);
         dx3_ff <= dx2_ff; dy3_ff <= dy2_ff;
         ax3_ff <= ax2_ff; ay3_ff <= ay2_ff; bx3_ff <= bx2_ff; by3_ff <= by2_ff;
      end
   end

   // stage 4: classify and pick the early result
   sel_type              sel4_ff;
   logic [SW-1:0]        rem4_ff, den4_ff;
   logic signed [DW-1:0] dx4_ff, dy4_ff;
   logic signed [CW-1:0] ax4_ff, ay4_ff, ex4_ff, ey4_ff;
   sel_type              sel_in;
   always_comb begin
      // zero length, or dot product negative or zero: start point
      if (len3_ff == '0 || dot3_ff[SW-1] || dot3_ff == '0) begin
         sel_in = SEL_START;
      end else if (dot3_ff >= len3_ff) begin
         sel_in = SEL_END;
      end else begin
         sel_in = SEL_RATIO;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         sel4_ff <= sel_in;
         rem4_ff <= (sel_in == SEL_RATIO) ? dot3_ff : '0;
         den4_ff <= len3_ff;
         dx4_ff <= dx3_ff; dy4_ff <= dy3_ff;
         ax4_ff <= ax3_ff; ay4_ff <= ay3_ff;
         ex4_ff <= (sel_in == SEL_END) ? bx3_ff : ax3_ff;
         ey4_ff <= (sel_in == SEL_END) ? by3_ff : ay3_ff;
      end
   end

   // divider chain, one quotient bit per stage; side data rides alongside
   logic [SW-1:0] rem_c [QW+1];
   logic [SW-1:0] den_c [QW+1];
   logic [QW-1:0] quo_c [QW+1];
   logic signed [DW-1:0] dx_c [QW+1], dy_c [QW+1];
   logic signed [CW-1:0] ax_c [QW+1], ay_c [QW+1], ex_c [QW+1], ey_c [QW+1];
   sel_type sel_c [QW+1];
   assign rem_c[0] = rem4_ff;
   assign den_c[0] = den4_ff;
   assign quo_c[0] = '0;
   assign dx_c[0] = dx4_ff; assign dy_c[0] = dy4_ff;
   assign ax_c[0] = ax4_ff; assign ay_c[0] = ay4_ff;
   assign ex_c[0] = ex4_ff; assign ey_c[0] = ey4_ff;
   assign sel_c[0] = sel4_ff;

   for (genvar i = 0; i < QW; i++) begin : g_div
      logic signed [DW-1:0] dx_ff, dy_ff;
      logic signed [CW-1:0] ax_ff, ay_ff, ex_ff, ey_ff;
      sel_type              sel_ff;
      pseg_div_stage #(.REM_WIDTH(SW), .Q_WIDTH(QW)) u_step (
         .clock   (clock),
         .advance (advance),
         .rem_in  (rem_c[i]),
         .den_in  (den_c[i]),
         .quo_in  (quo_c[i]),
         .rem_out (rem_c[i+1]),
         .den_out (den_c[i+1]),
         .quo_out (quo_c[i+1])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            dx_ff <= dx_c[i]; dy_ff <= dy_c[i];
            ax_ff <= ax_c[i]; ay_ff <= ay_c[i];
            ex_ff <= ex_c[i]; ey_ff <= ey_c[i];
            sel_ff <= sel_c[i];
         end
      end
      assign dx_c[i+1] = dx_ff; assign dy_c[i+1] = dy_ff;
      assign ax_c[i+1] = ax_ff; assign ay_c[i+1] = ay_ff;
      assign ex_c[i+1] = ex_ff; assign ey_c[i+1] = ey_ff;
      assign sel_c[i+1] = sel_ff;
   end

   // scale stage: d * q, floor by arithmetic shift
   localparam int MW = DW + QW + 1;
   logic signed [MW-1:0] mx_ff, my_ff;
   logic signed [CW-1:0] axm_ff, aym_ff, exm_ff, eym_ff;
   sel_type              selm_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff <= MW'(dx_c[QW]) * $signed({1'b0, quo_c[QW]});
         my_ff <= MW'(dy_c[QW]) * $signed({1'b0, quo_c[QW]});
         axm_ff <= ax_c[QW]; aym_ff <= ay_c[QW];
         exm_ff <= ex_c[QW]; eym_ff <= ey_c[QW];
         selm_ff <= sel_c[QW];
      end
   end

   // output register
   logic [MW-1:0] shx, shy;
   logic [CW-1:0] ox_ff, oy_ff;
   assign shx = MW'(mx_ff >>> QW);
   assign shy = MW'(my_ff >>> QW);
   always_ff @(posedge clock) begin
      if (advance) begin
         if (selm_ff == SEL_RATIO) begin
            ox_ff <= axm_ff + shx[CW-1:0];
            oy_ff <= aym_ff + shy[CW-1:0];
         end else begin
            ox_ff <= exm_ff;
            oy_ff <= eym_ff;
         end
      end
   end
   assign rsp_tdata = {oy_ff, ox_ff};

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // the input is refused only while a result waits
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without cause");
   // remainder stays below divisor inside the ratio path
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] && sel4_ff == SEL_RATIO |-> rem4_ff < den4_ff)
      else $error("ratio out of range");
endmodule

[verif/tb_top.sv]
// Testbench for point_to_segment_projection: closest point on a segment.
// Self-checking stream test with a bit-exact predictor; depends on the DUT only.
`timescale 1ns / 1ps

module tb_top;
   localparam int CW = 32;
   localparam int RF = 24;
   localparam int LATENCY = RF + 6;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic signed [CW-1:0] end_y, end_x, start_y, start_x, pt_y, pt_x;
   } query_t;

   typedef struct packed {
      logic signed [CW-1:0] y, x;
   } proj_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [6*CW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [2*CW-1:0] rsp_tdata;

   query_t pending_q[$];
   proj_t  proj_expected[$];
   int errors = 0;
   int n_checked = 0;
   int idle_cycles = 0;
   bit stim_done = 0;
   bit hold_off = 0;
   bit drain_pause = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_phase = 0;

   point_to_segment_projection dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // One coordinate placed along the segment: a + floor(d*q / 2^RF).
   function automatic logic signed [CW-1:0] place_coord(
      logic signed [CW:0] a, logic signed [CW:0] d, logic [RF-1:0] q);
      logic signed [CW+RF+2:0] prod;
      logic signed [CW+RF+2:0] shifted;
      prod = d * $signed({1'b0, q});
      shifted = prod >>> RF;
      return CW'(a + shifted);
   endfunction

   function automatic proj_t project_point(query_t it);
      logic signed [CW:0] dx, dy, wx, wy;
      logic signed [2*CW+3:0] dotp, len2, rem;
      logic [RF-1:0] q;
      proj_t r;
      dx = it.end_x - it.start_x;
      dy = it.end_y - it.start_y;
      wx = it.pt_x - it.start_x;
      wy = it.pt_y - it.start_y;
      dotp = wx * dx + wy * dy;
      len2 = dx * dx + dy * dy;
      if (len2 == 0 || dotp <= 0) begin
         r.x = it.start_x;
         r.y = it.start_y;
      end else if (dotp >= len2) begin
         r.x = it.end_x;
         r.y = it.end_y;
      end else begin
         rem = dotp;
         q = '0;
         for (int i = 0; i < RF; i++) begin
            rem = rem <<< 1;
            q = {q[RF-2:0], 1'b0};
            if (rem >= len2) begin
               rem = rem - len2;
               q[0] = 1'b1;
            end
         end
         r.x = place_coord(it.start_x, dx, q);
         r.y = place_coord(it.start_y, dy, q);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return CW'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         2: return CW'($signed($urandom_range(0, 200)) - 100);
         default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                               : 32'h80000000 + $urandom_range(0, 3);
      endcase
   endfunction

   // Driver: random bursts and gaps; an offered word is held until taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            proj_expected.push_back(project_point(query_t'(req_tdata)));
            void'(pending_q.pop_front());
            if (burst_left > 0)
               burst_left = burst_left - 1;
            if (burst_left == 0)
               gap_left = $urandom_range(0, 6);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() > 0 && !drain_pause && burst_left > 0) begin
               req_tdata <= pending_q[0];
               req_tvalid <= 1;
            end else begin
               req_tvalid <= 0;
               if (gap_left > 0)
                  gap_left = gap_left - 1;
               else if (burst_left == 0)
                  burst_left = $urandom_range(1, 40);
            end
         end
      end
   end

   // Receiver stall pattern, with an optional long hold-off.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_off)
         rsp_tready <= 0;
      else if (stall_phase % 512 < 128)
         rsp_tready <= 1;
      else
         rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   // Monitor: compare each response word with the oldest prediction.
   always @(posedge clock) begin
      proj_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = proj_t'(rsp_tdata);
         if (proj_expected.size() == 0) begin
            $display("%0t: unexpected word x=%h y=%h", $time, got.x, got.y);
            errors++;
         end else begin
            want = proj_expected.pop_front();
            n_checked++;
            if (got.x !== want.x) begin
               $display("%0t: proj_x expected %h actual %h", $time, want.x, got.x);
               errors++;
            end
            if (got.y !== want.y) begin
               $display("%0t: proj_y expected %h actual %h", $time, want.y, got.y);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off)
         idle_cycles <= 0;
      else if (!reset && !(stim_done && proj_expected.size() == 0 && pending_q.size() == 0))
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic query_t q_of(int ax, int ay, int bx, int by, int px, int py);
      query_t it;
      it.start_x = ax; it.start_y = ay; it.end_x = bx;
      it.end_y = by; it.pt_x = px; it.pt_y = py;
      return it;
   endfunction

   initial begin
      query_t it;
      int m;
      localparam int ONE = 32'h10000;
      localparam int MAXC = 32'h7fffffff;
      localparam int MINC = 32'h80000000;
      // Directed: interior, both clamps, zero length, ratio rounding to zero, extremes.
      pending_q.push_back(q_of(0, 0, 10*ONE, 0, 3*ONE, 5*ONE));
      pending_q.push_back(q_of(0, 0, 10*ONE, 0, -3*ONE, 1));
      pending_q.push_back(q_of(0, 0, 10*ONE, 0, 12*ONE, -7));
      pending_q.push_back(q_of(5, 7, 5, 7, 100, -100));
      pending_q.push_back(q_of(MINC, MINC, MINC, MINC, MAXC, MAXC));
      pending_q.push_back(q_of(0, 0, MAXC, MAXC, 1, 0));
      pending_q.push_back(q_of(MINC, MINC, MAXC, MAXC, 0, 0));
      pending_q.push_back(q_of(MAXC, MAXC, MINC, MINC, 1, -1));
      pending_q.push_back(q_of(MAXC, MINC, MINC, MAXC, MAXC, MAXC));
      pending_q.push_back(q_of(MINC, 0, MAXC, 0, MAXC, MINC));
      pending_q.push_back(q_of(0, 0, 3, 7, 2, 2));
      pending_q.push_back(q_of(0, 0, -3, -7, -2, -2));
      pending_q.push_back(q_of(-1, -1, -1, -1, -1, -1));
      pending_q.push_back(q_of(0, 0, 0, -1, 0, 0));
      pending_q.push_back(q_of(ONE, ONE, 2*ONE, 2*ONE, 2*ONE, 2*ONE));
      for (int i = 0; i < 800; i++) begin
         m = $urandom_range(0, 9);
         it.start_x = rand_coord(m % 4); it.start_y = rand_coord(m % 4);
         it.end_x = rand_coord(m % 4);   it.end_y = rand_coord(m % 4);
         it.pt_x = rand_coord(m % 4);    it.pt_y = rand_coord(m % 4);
         if (m == 9) begin
            it.end_x = it.start_x;
            it.end_y = it.start_y;
         end
         pending_q.push_back(it);
      end
      repeat (11) @(posedge clock);
      reset <= 0;
      // Long receiver hold-off while words keep arriving.
      repeat (200) @(posedge clock);
      hold_off <= 1;
      repeat (300) @(posedge clock);
      hold_off <= 0;
      // Sender pause until all outstanding words drain.
      wait (pending_q.size() < 400);
      @(posedge clock);
      drain_pause <= 1;
      wait (proj_expected.size() == 0 && !req_tvalid);
      @(posedge clock);
      drain_pause <= 0;
      wait (pending_q.size() == 0 && !req_tvalid);
      stim_done = 1;
      wait (proj_expected.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d projections: clamps, zero-length and interior cases,", n_checked);
      $display("with bursty input, random output stalls and a long hold-off.");
      if (errors == 0 && proj_expected.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
